@@ hw/rtl/sorted_priority_message_queue_top_defines.svh @@
// Assertion macros used by the queue datapath.
`ifndef SORTED_PRIORITY_MESSAGE_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_MESSAGE_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPMQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spmq assertion failed");

// Next-cycle implication, disabled during reset.
`define SPMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spmq assertion failed");

`endif

@@ hw/rtl/spmq_pkg.sv @@
package spmq_pkg;

   typedef enum logic {
      CTL_IDLE,
      CTL_EXEC
   } ctl_state_type;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_POP    = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic capture;
      logic exec;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

@@ hw/rtl/sorted_priority_message_queue_top.sv @@
// Sorted priority queue held in a row of register cells, front entry at cell 0.
// Result: registered at the execute edge that follows the request transfer, held back
// while the previous result is still held by rsp_stall.
// Requests: the compare-and-shift pass over all cells is combinational, and the
// controller takes no new request until the result of the last one is registered.
// Reset: synchronous, clears the entry count and the result valid; cell contents are
// left as they are and never read until written.
module sorted_priority_message_queue_top #(
   parameter int DEPTH          = 16,
   parameter int PRIORITY_WIDTH = 8,
   parameter int TIME_WIDTH     = 16,
   parameter int PAYLOAD_WIDTH  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_type,
   input  logic [PRIORITY_WIDTH-1:0]       req_priority,
   input  logic [TIME_WIDTH-1:0]           req_time_stamp,
   input  logic [PAYLOAD_WIDTH-1:0]        req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_out_valid,
   output logic [PAYLOAD_WIDTH-1:0]        rsp_out_payload,
   output logic [PRIORITY_WIDTH-1:0]       rsp_out_priority,
   output logic [TIME_WIDTH-1:0]           rsp_out_time_stamp,
   output logic [$clog2(DEPTH + 1)-1:0]    rsp_occupancy
);
   import spmq_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   spmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   spmq_datapath #(
      .DEPTH          (DEPTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH),
      .TIME_WIDTH     (TIME_WIDTH),
      .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
      .CNT_W          ($clog2(DEPTH + 1))
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .dp_cmd             (dp_cmd),
      .dp_status          (dp_status),
      .req_type           (req_type),
      .req_priority       (req_priority),
      .req_time_stamp     (req_time_stamp),
      .req_payload        (req_payload),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_out_payload    (rsp_out_payload),
      .rsp_out_priority   (rsp_out_priority),
      .rsp_out_time_stamp (rsp_out_time_stamp),
      .rsp_occupancy      (rsp_occupancy)
   );

endmodule

@@ hw/rtl/spmq_ctrl.sv @@
module spmq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  spmq_pkg::dp_status_type dp_status,
   output spmq_pkg::dp_cmd_type    dp_cmd
);
   import spmq_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               state_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            // hold until the result register can take the outcome
            if (dp_status.out_free) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      dp_cmd    = '0;
      req_stall = 1'b1;
      case (state_ff)
         CTL_IDLE: begin
            req_stall      = 1'b0;
            dp_cmd.capture = req_valid;
         end
         CTL_EXEC: begin
            dp_cmd.exec = dp_status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

@@ hw/rtl/spmq_datapath.sv @@
`include "sorted_priority_message_queue_top_defines.svh"

module spmq_datapath #(
   parameter int DEPTH          = 16,
   parameter int PRIORITY_WIDTH = 8,
   parameter int TIME_WIDTH     = 16,
   parameter int PAYLOAD_WIDTH  = 16,
   parameter int CNT_W          = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  spmq_pkg::dp_cmd_type      dp_cmd,
   output spmq_pkg::dp_status_type   dp_status,
   input  logic                      req_type,
   input  logic [PRIORITY_WIDTH-1:0] req_priority,
   input  logic [TIME_WIDTH-1:0]     req_time_stamp,
   input  logic [PAYLOAD_WIDTH-1:0]  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic                      rsp_out_valid,
   output logic [PAYLOAD_WIDTH-1:0]  rsp_out_payload,
   output logic [PRIORITY_WIDTH-1:0] rsp_out_priority,
   output logic [TIME_WIDTH-1:0]     rsp_out_time_stamp,
   output logic [CNT_W-1:0]          rsp_occupancy
);
   import spmq_pkg::*;

   // captured request
   logic                      op_ff;
   logic [PRIORITY_WIDTH-1:0] new_prio_ff;
   logic [TIME_WIDTH-1:0]     new_ts_ff;
   logic [PAYLOAD_WIDTH-1:0]  new_tag_ff;

   // entry cells, front of the queue at index 0
   logic [PRIORITY_WIDTH-1:0] prio_ff [DEPTH];
   logic [TIME_WIDTH-1:0]     ts_ff   [DEPTH];
   logic [PAYLOAD_WIDTH-1:0]  tag_ff  [DEPTH];
   logic [PRIORITY_WIDTH-1:0] prio_in [DEPTH];
   logic [TIME_WIDTH-1:0]     ts_in   [DEPTH];
   logic [PAYLOAD_WIDTH-1:0]  tag_in  [DEPTH];
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;

   // result register
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [1:0]                status_ff;
   logic [1:0]                status_in;
   logic                      msg_valid_ff;
   logic                      msg_valid_in;
   logic [PAYLOAD_WIDTH-1:0]  out_tag_ff;
   logic [PAYLOAD_WIDTH-1:0]  out_tag_in;
   logic [PRIORITY_WIDTH-1:0] out_prio_ff;
   logic [PRIORITY_WIDTH-1:0] out_prio_in;
   logic [TIME_WIDTH-1:0]     out_ts_ff;
   logic [TIME_WIDTH-1:0]     out_ts_in;

   logic             is_full;
   logic             is_empty;
   logic             do_pop;
   logic             do_ins;
   logic [DEPTH-1:0] outrank;

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign do_pop   = dp_cmd.exec && (op_ff == REQ_POP) && !is_empty;
   assign do_ins   = dp_cmd.exec && (op_ff == REQ_INSERT) && !is_full;

   assign dp_status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         op_ff       <= req_type;
         new_prio_ff <= req_priority;
         new_ts_ff   <= req_time_stamp;
         new_tag_ff  <= req_payload;
      end
   end

   // Each cell compares against the new entry; unused cells count as outranked,
   // so the flags form a run from the insertion point to the end.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                      prev_outrank;
      logic [PRIORITY_WIDTH-1:0] lo_prio;
      logic [TIME_WIDTH-1:0]     lo_ts;
      logic [PAYLOAD_WIDTH-1:0]  lo_tag;
      logic [PRIORITY_WIDTH-1:0] hi_prio;
      logic [TIME_WIDTH-1:0]     hi_ts;
      logic [PAYLOAD_WIDTH-1:0]  hi_tag;

      if (i == 0) begin : g_first
         assign prev_outrank = 1'b0;
         assign lo_prio      = new_prio_ff;
         assign lo_ts        = new_ts_ff;
         assign lo_tag       = new_tag_ff;
      end else begin : g_inner
         assign prev_outrank = outrank[i-1];
         assign lo_prio      = prio_ff[i-1];
         assign lo_ts        = ts_ff[i-1];
         assign lo_tag       = tag_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign hi_prio = prio_ff[i];
         assign hi_ts   = ts_ff[i];
         assign hi_tag  = tag_ff[i];
      end else begin : g_body
         assign hi_prio = prio_ff[i+1];
         assign hi_ts   = ts_ff[i+1];
         assign hi_tag  = tag_ff[i+1];
      end

      assign outrank[i] = (CNT_W'(i) >= count_ff) || (new_prio_ff > prio_ff[i]) ||
                          ((new_prio_ff == prio_ff[i]) && (new_ts_ff < ts_ff[i]));

      always_comb begin
         prio_in[i] = prio_ff[i];
         ts_in[i]   = ts_ff[i];
         tag_in[i]  = tag_ff[i];
         if (do_pop) begin
            // advance toward the front
            prio_in[i] = hi_prio;
            ts_in[i]   = hi_ts;
            tag_in[i]  = hi_tag;
         end else if (do_ins && outrank[i]) begin
            if (prev_outrank) begin
               prio_in[i] = lo_prio;
               ts_in[i]   = lo_ts;
               tag_in[i]  = lo_tag;
            end else begin
               prio_in[i] = new_prio_ff;
               ts_in[i]   = new_ts_ff;
               tag_in[i]  = new_tag_ff;
            end
         end
      end

      always_ff @(posedge clock) begin
         prio_ff[i] <= prio_in[i];
         ts_ff[i]   <= ts_in[i];
         tag_ff[i]  <= tag_in[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_pop) begin
         count_in = count_ff - 1'b1;
      end else if (do_ins) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      msg_valid_in = msg_valid_ff;
      out_tag_in   = out_tag_ff;
      out_prio_in  = out_prio_ff;
      out_ts_in    = out_ts_ff;
      if (dp_cmd.exec) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         msg_valid_in = 1'b0;
         out_tag_in   = '0;
         out_prio_in  = '0;
         out_ts_in    = '0;
         if (op_ff == REQ_POP) begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               msg_valid_in = 1'b1;
               out_tag_in   = tag_ff[0];
               out_prio_in  = prio_ff[0];
               out_ts_in    = ts_ff[0];
            end
         end else if (is_full) begin
            status_in = ST_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      msg_valid_ff <= msg_valid_in;
      out_tag_ff   <= out_tag_in;
      out_prio_ff  <= out_prio_in;
      out_ts_ff    <= out_ts_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_out_valid      = msg_valid_ff;
   assign rsp_out_payload    = out_tag_ff;
   assign rsp_out_priority   = out_prio_ff;
   assign rsp_out_time_stamp = out_ts_ff;
   assign rsp_occupancy      = count_ff;

   `SPMQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `SPMQ_ASSERT_NEXT(a_insert_grows, clock, reset, do_ins,
      count_ff == $past(count_ff) + 1'b1)
   `SPMQ_ASSERT_NEXT(a_pop_advances, clock, reset, do_pop && (count_ff > CNT_W'(1)),
      prio_ff[0] == $past(prio_ff[1]) && ts_ff[0] == $past(ts_ff[1]))
   `SPMQ_ASSERT_NOW(a_front_sorted, clock, reset, count_ff > CNT_W'(1),
      (prio_ff[0] > prio_ff[1]) || ((prio_ff[0] == prio_ff[1]) && (ts_ff[0] <= ts_ff[1])))

endmodule
